@@ rtl/core/lgs_pkg.sv @@
// shared types, command codes and the life rule for the life grid block
package lgs_pkg;

    // fixed widths of the request and result fields
    localparam int COORD_W = 7;
    localparam int CMD_W   = 2;
    localparam int NBR_W   = 4;

    typedef logic [CMD_W-1:0]   t_cmd;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [NBR_W-1:0]   t_nbr_count;

    // command codes
    localparam t_cmd CMD_SET     = 2'd0;
    localparam t_cmd CMD_CLEAR   = 2'd1;
    localparam t_cmd CMD_ADVANCE = 2'd2;
    localparam t_cmd CMD_READ    = 2'd3;

    // neighbor counts that keep or create a live cell
    localparam t_nbr_count KEEP_LO = 4'd2;
    localparam t_nbr_count BIRTH   = 4'd3;

    // survival with two or three neighbors, birth with exactly three
    function automatic logic life_rule(input logic alive, input t_nbr_count count);
        logic keep;
        keep = (count == KEEP_LO) || (count == BIRTH);
        return alive ? keep : (count == BIRTH);
    endfunction

endpackage

@@ rtl/core/lgs_if.sv @@
// request and result channel interfaces of the life grid block
interface lgs_cmd_if import lgs_pkg::*; ();
    logic   valid;
    logic   ready;
    t_cmd   command;
    t_coord cell_x;
    t_coord cell_y;

    modport source (output valid, output command, output cell_x, output cell_y,
                    input ready);
    modport sink   (input valid, input command, input cell_x, input cell_y,
                    output ready);
endinterface

interface lgs_res_if import lgs_pkg::*; ();
    logic valid;
    logic ready;
    logic cell_live;
    logic done_res;

    modport source (output valid, output cell_live, output done_res, input ready);
    modport sink   (input valid, input cell_live, input done_res, output ready);
endinterface

@@ rtl/core/lgs_bank_mem.sv @@
// one-port-write, one-port-read synchronous memory holding both cell banks
module lgs_bank_mem #(
    parameter int DEPTH = 256,
    parameter int WIDTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rd_data <= r_mem[i_raddr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/lgs_next_gen.sv @@
// next generation of one grid column from the column and its two wrapped neighbors
module lgs_next_gen import lgs_pkg::*; #(
    parameter int GRID_SIZE = 128
) (
    input  logic [GRID_SIZE-1:0] i_prev,
    input  logic [GRID_SIZE-1:0] i_cur,
    input  logic [GRID_SIZE-1:0] i_next,
    output logic [GRID_SIZE-1:0] o_new
);

    // one lane per cell, neighbors along the column wrap around
    for (genvar y = 0; y < GRID_SIZE; y++) begin : g_lane
        localparam int YM = (y == 0) ? GRID_SIZE - 1 : y - 1;
        localparam int YP = (y == GRID_SIZE - 1) ? 0 : y + 1;
        t_nbr_count count;

        assign count = NBR_W'(i_prev[YM]) + NBR_W'(i_prev[y]) + NBR_W'(i_prev[YP])
                     + NBR_W'(i_cur[YM])                      + NBR_W'(i_cur[YP])
                     + NBR_W'(i_next[YM]) + NBR_W'(i_next[y]) + NBR_W'(i_next[YP]);
        assign o_new[y] = life_rule(i_cur[y], count);
    end

endmodule

@@ rtl/core/life_grid_generation_step.sv @@
// top level of the toroidal life grid: command sequencer around the bank memory
//
//  channel | dir | modport | payload
//  i_cmd   | in  | sink    | command, cell_x, cell_y
//  o_res   | out | source  | cell_live, done_res
//
// set and read run through read, modify or sample, then result; clear zeroes
// every column of the current bank; advance streams one column word per cycle
// through the memory read port into the next-gen lanes. after reset a clearing
// pass zeroes bank 0; no request is taken meanwhile. a result waits in the
// output register while the next request is taken; a new result stalls until
// that register is free.
module life_grid_generation_step import lgs_pkg::*; #(
    parameter int GRID_SIZE = 128
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    lgs_cmd_if.sink   i_cmd,
    lgs_res_if.source o_res
);

    localparam int XW     = $clog2(GRID_SIZE);
    localparam int AW     = XW + 1;
    localparam int DEPTH  = 2 << XW;
    localparam int CW     = $clog2(GRID_SIZE + 3);
    localparam int CMP_W  = ((XW > COORD_W) ? XW : COORD_W) + 1;
    localparam logic [XW-1:0]    LAST_X  = XW'(GRID_SIZE - 1);
    localparam logic [CW-1:0]    RD_LAST = CW'(GRID_SIZE + 1);
    localparam logic [CW-1:0]    RD_END  = CW'(GRID_SIZE + 2);
    localparam logic [CW-1:0]    WIN_OK  = CW'(2);
    localparam logic [CMP_W-1:0] LIMIT   = CMP_W'(GRID_SIZE);

    // sequencer states
    localparam logic [2:0] S_INIT  = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RMW   = 3'd2;
    localparam logic [2:0] S_CLEAR = 3'd3;
    localparam logic [2:0] S_ADV   = 3'd4;
    localparam logic [2:0] S_PUSH  = 3'd5;

    logic [2:0]           r_state, n_state;
    logic                 r_bank, n_bank;
    logic [XW-1:0]        r_cnt, n_cnt;
    logic [CW-1:0]        r_rd_cnt, n_rd_cnt;
    logic [CW-1:0]        r_rd_k;
    logic                 r_rd_vld;
    t_cmd                 r_cmd, n_cmd;
    logic [XW-1:0]        r_x, n_x;
    logic [XW-1:0]        r_y, n_y;
    logic                 r_res_live, n_res_live;
    logic                 r_out_vld, n_out_vld;
    logic                 r_out_live, n_out_live;
    logic [GRID_SIZE-1:0] r_win_prev, r_win_cur;

    logic                 mem_we, mem_re;
    logic [AW-1:0]        mem_waddr, mem_raddr;
    logic [GRID_SIZE-1:0] mem_wdata, rd_data, new_word, set_word;
    logic                 cmd_accept, in_grid;

    lgs_bank_mem #(
        .DEPTH (DEPTH),
        .WIDTH (GRID_SIZE)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (mem_we),
        .i_waddr   (mem_waddr),
        .i_wdata   (mem_wdata),
        .i_re      (mem_re),
        .i_raddr   (mem_raddr),
        .o_rd_data (rd_data)
    );

    lgs_next_gen #(
        .GRID_SIZE (GRID_SIZE)
    ) u_next_gen (
        .i_prev (r_win_prev),
        .i_cur  (r_win_cur),
        .i_next (rd_data),
        .o_new  (new_word)
    );

    assign i_cmd.ready = (r_state == S_IDLE);
    assign cmd_accept  = i_cmd.valid && i_cmd.ready;
    assign in_grid     = (CMP_W'(i_cmd.cell_x) < LIMIT)
                      && (CMP_W'(i_cmd.cell_y) < LIMIT);

    // column word with the addressed cell set live
    always_comb begin
        set_word        = rd_data;
        set_word[r_y]   = 1'b1;
    end

    // sequencer and memory access
    always_comb begin
        n_state    = r_state;
        n_bank     = r_bank;
        n_cnt      = r_cnt;
        n_rd_cnt   = r_rd_cnt;
        n_cmd      = r_cmd;
        n_x        = r_x;
        n_y        = r_y;
        n_res_live = r_res_live;
        mem_we     = 1'b0;
        mem_waddr  = {r_bank, r_cnt};
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = {r_bank, r_x};

        unique case (r_state)
            S_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = {1'b0, r_cnt};
                n_cnt     = r_cnt + 1'b1;
                if (r_cnt == LAST_X) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (cmd_accept) begin
                    n_cmd      = i_cmd.command;
                    n_x        = XW'(i_cmd.cell_x);
                    n_y        = XW'(i_cmd.cell_y);
                    n_res_live = 1'b0;
                    n_cnt      = '0;
                    n_rd_cnt   = '0;
                    unique case (i_cmd.command)
                        CMD_SET, CMD_READ: begin
                            if (in_grid) begin
                                mem_re    = 1'b1;
                                mem_raddr = {r_bank, XW'(i_cmd.cell_x)};
                                n_state   = S_RMW;
                            end else begin
                                n_state   = S_PUSH;
                            end
                        end
                        CMD_CLEAR:   n_state = S_CLEAR;
                        CMD_ADVANCE: n_state = S_ADV;
                        default:     n_state = S_PUSH;
                    endcase
                end
            end
            S_RMW: begin
                if (r_cmd == CMD_SET) begin
                    mem_we    = 1'b1;
                    mem_waddr = {r_bank, r_x};
                    mem_wdata = set_word;
                end else begin
                    n_res_live = rd_data[r_y];
                end
                n_state = S_PUSH;
            end
            S_CLEAR: begin
                mem_we = 1'b1;
                n_cnt  = r_cnt + 1'b1;
                if (r_cnt == LAST_X) begin
                    n_state = S_PUSH;
                end
            end
            S_ADV: begin
                // stream columns N-1, 0, 1, ..., N-1, 0 from the current bank
                if (r_rd_cnt != RD_END) begin
                    mem_re   = 1'b1;
                    n_rd_cnt = r_rd_cnt + 1'b1;
                    if (r_rd_cnt == '0) begin
                        mem_raddr = {r_bank, LAST_X};
                    end else if (r_rd_cnt == RD_LAST) begin
                        mem_raddr = {r_bank, XW'(0)};
                    end else begin
                        mem_raddr = {r_bank, XW'(r_rd_cnt - 1'b1)};
                    end
                end
                // full window: write the new column into the other bank
                if (r_rd_vld && (r_rd_k >= WIN_OK)) begin
                    mem_we    = 1'b1;
                    mem_waddr = {~r_bank, XW'(r_rd_k - WIN_OK)};
                    mem_wdata = new_word;
                    if (r_rd_k == RD_LAST) begin
                        n_bank  = ~r_bank;
                        n_state = S_PUSH;
                    end
                end
            end
            S_PUSH: begin
                if (!r_out_vld || o_res.ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // output register
    always_comb begin
        n_out_vld  = r_out_vld && !o_res.ready;
        n_out_live = r_out_live;
        if ((r_state == S_PUSH) && (!r_out_vld || o_res.ready)) begin
            n_out_vld  = 1'b1;
            n_out_live = r_res_live;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_INIT;
            r_bank    <= 1'b0;
            r_cnt     <= '0;
            r_rd_cnt  <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_bank    <= n_bank;
            r_cnt     <= n_cnt;
            r_rd_cnt  <= n_rd_cnt;
            r_rd_vld  <= mem_re;
            r_out_vld <= n_out_vld;
        end
    end

    // payload registers and the column window
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_x        <= n_x;
        r_y        <= n_y;
        r_res_live <= n_res_live;
        r_out_live <= n_out_live;
        r_rd_k     <= r_rd_cnt;
        if (r_rd_vld && (r_state == S_ADV)) begin
            r_win_prev <= r_win_cur;
            r_win_cur  <= rd_data;
        end
    end

    assign o_res.valid     = r_out_vld;
    assign o_res.cell_live = r_out_live;
    assign o_res.done_res  = 1'b1;

    // an advance never writes the bank it is reading
    a_adv_other_bank: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADV) && mem_we |-> (mem_waddr[AW-1] != r_bank))
        else $error("advance wrote the active bank");

    // the bank flips exactly when an advance finishes
    a_adv_flip: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ADV) && (n_state == S_PUSH) |=> (r_bank != $past(r_bank)))
        else $error("bank did not flip after advance");

    // clearing passes write zeros only
    a_clear_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_we && ((r_state == S_CLEAR) || (r_state == S_INIT)) |-> (mem_wdata == '0))
        else $error("clearing pass wrote a live cell");

    // read data arrives only while a read is expected
    a_rd_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rd_vld |-> ((r_state == S_RMW) || (r_state == S_ADV)))
        else $error("memory read data outside a read sequence");

    // a finished request reaches the output register when it is free
    a_push_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_PUSH) && !r_out_vld |=> r_out_vld && (r_state == S_IDLE))
        else $error("result not loaded into a free output register");

endmodule

@@ bench/life_grid_generation_step_test.sv @@
// self-checking testbench for the toroidal life grid block: directed and random command streams vs a shadow grid
module life_grid_generation_step_test;
    import lgs_pkg::*;

    localparam int GRID     = 128;
    localparam int RAND_REQ = 76;
    localparam int TAIL_REQ = 15;

    typedef struct {
        t_cmd   cmd;
        t_coord x;
        t_coord y;
        int     gap;
        bit     drain;
    } t_grid_req;

    typedef struct {
        t_cmd cmd;
        logic cell_live;
        logic done_res;
    } t_grid_res;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    lgs_cmd_if cmd_if ();
    lgs_res_if res_if ();

    life_grid_generation_step #(.GRID_SIZE(GRID)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd_if),
        .o_res   (res_if)
    );

    // shadow copy of the current grid, indexed [x][y]
    logic [GRID-1:0] shadow_cells [GRID];

    t_grid_req request_q [$];
    t_grid_res pending_results [$];
    t_grid_req cur_req;
    t_grid_res want;

    int   err_count  = 0;
    int   n_accepted = 0;
    int   n_checked  = 0;
    int   live_reads = 0;
    int   cmd_count [4];
    int   gap_left   = 0;
    int   stall_left = 0;
    int   stall_pct  = 0;
    int   window_cnt = 0;
    logic quiet_tail = 1'b0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        err_count++;
    endtask

    task automatic push_request(input t_cmd c, input int x, input int y,
                                input int gap = 0, input bit drain = 1'b0);
        t_grid_req r;
        r.cmd   = c;
        r.x     = t_coord'(x);
        r.y     = t_coord'(y);
        r.gap   = gap;
        r.drain = drain;
        request_q.push_back(r);
    endtask

    // one generation on the torus, every new cell from the old grid
    function automatic void next_generation();
        logic [GRID-1:0] nxt [GRID];
        int xm, xp, ym, yp, n;
        for (int x = 0; x < GRID; x++) begin
            xm = (x + GRID - 1) % GRID;
            xp = (x + 1) % GRID;
            for (int y = 0; y < GRID; y++) begin
                ym = (y + GRID - 1) % GRID;
                yp = (y + 1) % GRID;
                n = int'(shadow_cells[xm][ym]) + int'(shadow_cells[x][ym])
                  + int'(shadow_cells[xp][ym]) + int'(shadow_cells[xm][y])
                  + int'(shadow_cells[xp][y])  + int'(shadow_cells[xm][yp])
                  + int'(shadow_cells[x][yp])  + int'(shadow_cells[xp][yp]);
                if (shadow_cells[x][y])
                    nxt[x][y] = (n == 2) || (n == 3);
                else
                    nxt[x][y] = (n == 3);
            end
        end
        shadow_cells = nxt;
    endfunction

    // apply one accepted command to the shadow grid and give the result it owes
    function automatic t_grid_res apply_command(input t_grid_req r);
        t_grid_res res;
        res.cmd       = r.cmd;
        res.cell_live = 1'b0;
        res.done_res  = 1'b1;
        case (r.cmd)
            CMD_SET: begin
                shadow_cells[r.x][r.y] = 1'b1;
            end
            CMD_CLEAR: begin
                foreach (shadow_cells[i]) shadow_cells[i] = '0;
            end
            CMD_ADVANCE: begin
                next_generation();
            end
            default: begin
                res.cell_live = shadow_cells[r.x][r.y];
            end
        endcase
        return res;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            cmd_if.valid <= 1'b0;
        end else begin
            if (cmd_if.valid && cmd_if.ready) begin
                pending_results.push_back(apply_command(cur_req));
                cmd_count[cur_req.cmd]++;
                n_accepted++;
            end
            quiet_tail <= (request_q.size() <= TAIL_REQ);
            if (!(cmd_if.valid && !cmd_if.ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    cmd_if.valid <= 1'b0;
                end else if (request_q.size() == 0 ||
                             (request_q[0].drain && pending_results.size() != 0)) begin
                    cmd_if.valid <= 1'b0;
                end else if (request_q[0].gap != 0) begin
                    gap_left = request_q[0].gap - 1;
                    request_q[0].gap = 0;
                    cmd_if.valid <= 1'b0;
                end else begin
                    cur_req = request_q.pop_front();
                    cmd_if.valid   <= 1'b1;
                    cmd_if.command <= cur_req.cmd;
                    cmd_if.cell_x  <= cur_req.x;
                    cmd_if.cell_y  <= cur_req.y;
                end
            end
        end
    end

    // result monitor with random back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result with no request pending, cell_live %b",
                                              res_if.cell_live));
                end else begin
                    want = pending_results.pop_front();
                    if (res_if.cell_live !== want.cell_live)
                        report_mismatch($sformatf("result %0d (cmd %0d): cell_live %b, want %b",
                                                  n_checked, want.cmd, res_if.cell_live,
                                                  want.cell_live));
                    if (res_if.done_res !== want.done_res)
                        report_mismatch($sformatf("result %0d (cmd %0d): done_res %b, want %b",
                                                  n_checked, want.cmd, res_if.done_res,
                                                  want.done_res));
                    if (want.cmd == CMD_READ && want.cell_live)
                        live_reads++;
                    n_checked++;
                end
            end
            // stall density is redrawn at random for each counting window, zero in some windows
            window_cnt++;
            if (window_cnt == 64) begin
                window_cnt = 0;
                case ($urandom_range(0, 2))
                    0: stall_pct = 0;
                    1: stall_pct = 10;
                    default: stall_pct = 35;
                endcase
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else if (!quiet_tail && $urandom_range(0, 99) < stall_pct) begin
                stall_left = $urandom_range(1, 13) - 1;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int total, n_rand, start, cx, cy, steps;
        bit first, busy;
        int dxq [$];
        int dyq [$];

        cmd_if.valid   = 1'b0;
        cmd_if.command = CMD_SET;
        cmd_if.cell_x  = '0;
        cmd_if.cell_y  = '0;
        res_if.ready   = 1'b0;
        foreach (shadow_cells[i]) shadow_cells[i] = '0;
        foreach (cmd_count[i]) cmd_count[i] = 0;

        // fresh grid reads dead at both corners
        push_request(CMD_READ, 0, 0);
        push_request(CMD_READ, 127, 127);
        // four corners touch across the wrap and form a still block
        push_request(CMD_SET, 0, 0);
        push_request(CMD_SET, 127, 127);
        push_request(CMD_SET, 127, 0);
        push_request(CMD_SET, 0, 127);
        push_request(CMD_READ, 0, 0);
        push_request(CMD_READ, 127, 127);
        push_request(CMD_READ, 1, 1);
        // coordinates on advance and clear must be ignored
        push_request(CMD_ADVANCE, 127, 127);
        push_request(CMD_READ, 0, 0);
        push_request(CMD_READ, 127, 0);
        push_request(CMD_CLEAR, 127, 127);
        push_request(CMD_READ, 0, 0);
        // blinker straddling the x edge
        push_request(CMD_SET, 127, 5);
        push_request(CMD_SET, 0, 5);
        push_request(CMD_SET, 1, 5);
        push_request(CMD_ADVANCE, 0, 0);
        push_request(CMD_READ, 0, 4);
        push_request(CMD_READ, 0, 5);
        push_request(CMD_READ, 0, 6);
        push_request(CMD_READ, 127, 5);
        push_request(CMD_ADVANCE, 64, 64);
        push_request(CMD_READ, 127, 5);

        // random part: mostly seeded patterns that are stepped and probed
        n_rand = 0;
        first  = 1'b1;
        while (n_rand < RAND_REQ) begin
            start = request_q.size();
            busy  = ($urandom_range(0, 9) < 4);
            if ($urandom_range(0, 9) < 7) begin
                cx = $urandom_range(0, 127);
                cy = $urandom_range(0, 127);
                if ($urandom_range(0, 1))
                    push_request(CMD_CLEAR, $urandom_range(0, 127), $urandom_range(0, 127));
                case ($urandom_range(0, 2))
                    0: begin
                        dxq = '{1, 2, 0, 1, 2};
                        dyq = '{0, 1, 2, 2, 2};
                    end
                    1: begin
                        dxq = '{0, 1, 2};
                        dyq = '{1, 1, 1};
                    end
                    default: begin
                        dxq = {};
                        dyq = {};
                        repeat ($urandom_range(3, 9)) begin
                            dxq.push_back($urandom_range(0, 4));
                            dyq.push_back($urandom_range(0, 4));
                        end
                    end
                endcase
                foreach (dxq[i])
                    push_request(CMD_SET, cx + dxq[i], cy + dyq[i]);
                steps = $urandom_range(1, 3);
                repeat (steps) begin
                    push_request(CMD_ADVANCE, $urandom_range(0, 127), $urandom_range(0, 127));
                    repeat ($urandom_range(2, 5))
                        push_request(CMD_READ, cx + $urandom_range(0, 6) - 1,
                                     cy + $urandom_range(0, 6) - 1);
                end
            end else begin
                // noise: any command anywhere
                repeat ($urandom_range(3, 8))
                    push_request(t_cmd'($urandom_range(0, 3)), $urandom_range(0, 127),
                                 $urandom_range(0, 127));
            end
            for (int i = start; i < request_q.size(); i++)
                request_q[i].gap = (!busy && $urandom_range(0, 3) == 0) ?
                                   $urandom_range(1, 13) : 0;
            // hold the first random request until the directed results are all back
            if (first)
                request_q[start].drain = 1'b1;
            first  = 1'b0;
            n_rand += request_q.size() - start;
        end
        for (int i = request_q.size() - TAIL_REQ; i < request_q.size(); i++)
            request_q[i].gap = 0;
        total = request_q.size();

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (n_accepted < total || pending_results.size() != 0)
            @(posedge i_clk);
        repeat (GRID + 16) @(posedge i_clk);

        $display("covered %0d sets, %0d clears, %0d advances, %0d reads (%0d read live)",
                 cmd_count[CMD_SET], cmd_count[CMD_CLEAR], cmd_count[CMD_ADVANCE],
                 cmd_count[CMD_READ], live_reads);
        $display("checked %0d results under random gaps and stalls, %0d mismatches",
                 n_checked, err_count);
        if (err_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial begin
        #(8 * 500000);
        $display("simulation failed");
        $finish;
    end

endmodule

@@ life_grid_generation_step.f @@
rtl/core/lgs_pkg.sv
rtl/core/lgs_if.sv
rtl/core/lgs_bank_mem.sv
rtl/core/lgs_next_gen.sv
rtl/core/life_grid_generation_step.sv
bench/life_grid_generation_step_test.sv
